### rtl/tssd_pkg.sv
// Package for the temperature sensor scratchpad decoder.
// Holds the scratchpad constants, the CRC-8 byte update and the temperature decode.
// Standalone package; used by temp_sensor_scratchpad_decode.
`timescale 1ns / 1ps

package tssd_pkg;

   localparam logic [7:0]  CRC_POLY_REFLECTED  = 8'h8C;
   localparam logic [7:0]  FAMILY_COUNT_REMAIN = 8'h10;
   localparam logic [7:0]  FAMILY_RESET        = 8'h28;
   localparam logic [7:0]  COUNT_PER_C_MARK    = 8'h10;
   localparam logic [7:0]  RES_FIELD_MASK      = 8'h60;
   localparam logic [7:0]  RES_9_BIT           = 8'h00;
   localparam logic [7:0]  RES_10_BIT          = 8'h20;
   localparam logic [7:0]  RES_11_BIT          = 8'h40;
   localparam logic [15:0] HIGH_NIBBLES_MASK   = 16'hFFF0;
   localparam logic [15:0] COUNT_REMAIN_BIAS   = 16'd12;
   localparam logic [3:0]  CRC_BYTE_INDEX      = 4'd8;

   // register word index on the configuration port
   localparam logic        REG_FAMILY_CODE     = 1'b0;

   typedef struct packed {
      logic [15:0] temperature;
      logic        crc_ok;
      logic [7:0]  computed_crc;
   } result_type;

   // One byte of the reflected CRC-8, least significant bit first.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      logic       mix;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         mix = c[0] ^ b[i];
         c   = {1'b0, c[7:1]};
         if (mix) begin
            c = c ^ CRC_POLY_REFLECTED;
         end
      end
      return c;
   endfunction

   function automatic logic [15:0] decode_temperature(
      input logic [7:0] family,
      input logic [7:0] b0,
      input logic [7:0] b1,
      input logic [7:0] b4,
      input logic [7:0] b6,
      input logic [7:0] b7
   );
      logic [15:0] raw;
      logic [7:0]  res;
      raw = {b1, b0};
      res = b4 & RES_FIELD_MASK;
      if (family == FAMILY_COUNT_REMAIN) begin
         raw = {raw[12:0], 3'b000};
         if (b7 == COUNT_PER_C_MARK) begin
            raw = (raw & HIGH_NIBBLES_MASK) + COUNT_REMAIN_BIAS - {8'h00, b6};
         end
      end else begin
         case (res)
            RES_9_BIT:  raw = {raw[15:3], 3'b000};
            RES_10_BIT: raw = {raw[15:2], 2'b00};
            RES_11_BIT: raw = {raw[15:1], 1'b0};
            default:    raw = raw;
         endcase
      end
      return raw;
   endfunction

endpackage

### rtl/temp_sensor_scratchpad_decode.sv
// Top level of the temperature sensor scratchpad decoder.
// Streaming byte input, streaming result output, APB-style family code register.
// Depends on tssd_pkg.
`timescale 1ns / 1ps

// Takes one scratchpad byte per cycle (byte 0 to byte 8) and, in the cycle after byte 8 is
// accepted, presents one result: temperature in sixteenths of a degree C, the CRC match
// flag and the computed CRC-8. The CRC update and the decode are combinational logic between
// the input handshake and the result register, so a byte can enter in every cycle; req_tready
// drops only while a finished result is held and rsp_tready is low. req_tuser high restarts
// the frame at byte 0. Write the family code only while the block is idle.
module temp_sensor_scratchpad_decode (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] temperature, [16] crc_ok,
                                    // [24:17] computed_crc, [31:25] zero
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0]             family_ff, family_in;
   logic [3:0]             count_ff, count_in;
   logic [7:0]             crc_ff, crc_in;
   logic [7:0]             byte0_ff, byte1_ff, byte4_ff, byte6_ff, byte7_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   tssd_pkg::result_type   rsp_data_ff, rsp_data_in;

   logic       req_fire;
   logic       is_crc_byte;
   logic [3:0] eff_count;
   logic [7:0] eff_crc;
   logic       reg_write;

   assign csr_pready = 1'b1;
   assign reg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == tssd_pkg::REG_FAMILY_CODE);
   assign csr_prdata = (csr_paddr[2] == tssd_pkg::REG_FAMILY_CODE) ? {24'h000000, family_ff}
                                                                    : 32'h00000000;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // frame start drops any partial frame before this byte is counted
   assign eff_count   = req_tuser ? 4'd0 : count_ff;
   assign eff_crc     = req_tuser ? 8'h00 : crc_ff;
   assign is_crc_byte = (eff_count >= tssd_pkg::CRC_BYTE_INDEX);

   always_comb begin
      family_in = reg_write ? csr_pwdata[7:0] : family_ff;
   end

   always_comb begin
      count_in     = count_ff;
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (req_fire) begin
         if (is_crc_byte) begin
            count_in                 = 4'd0;
            crc_in                   = 8'h00;
            rsp_valid_in             = 1'b1;
            rsp_data_in.temperature  = tssd_pkg::decode_temperature(family_ff, byte0_ff,
                                          byte1_ff, byte4_ff, byte6_ff, byte7_ff);
            rsp_data_in.crc_ok       = (eff_crc == req_tdata);
            rsp_data_in.computed_crc = eff_crc;
         end else begin
            count_in = eff_count + 4'd1;
            crc_in   = tssd_pkg::crc8_update(eff_crc, req_tdata);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         family_ff    <= tssd_pkg::FAMILY_RESET;
         count_ff     <= 4'd0;
         crc_ff       <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else begin
         family_ff    <= family_in;
         count_ff     <= count_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // keep only the scratchpad bytes that the decode reads
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (req_fire && !is_crc_byte) begin
         case (eff_count[2:0])
            3'd0:    byte0_ff <= req_tdata;
            3'd1:    byte1_ff <= req_tdata;
            3'd4:    byte4_ff <= req_tdata;
            3'd6:    byte6_ff <= req_tdata;
            3'd7:    byte7_ff <= req_tdata;
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0000000, rsp_data_ff.computed_crc, rsp_data_ff.crc_ok,
                        rsp_data_ff.temperature};

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tssd_pkg::CRC_BYTE_INDEX)
      else $error("byte count beyond the CRC byte");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_fire && !req_tuser &&
                                    (count_ff >= tssd_pkg::CRC_BYTE_INDEX)))
      else $error("result raised without a CRC byte transaction");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_crc_byte) |=> (count_ff == 4'd0) && (crc_ff == 8'h00) && rsp_valid_ff)
      else $error("frame state not restarted after the CRC byte");
`endif

endmodule
